### rtl/c8_pkg.sv
// shared types, constants and font table for the chip8 core
package c8_pkg;

    localparam int MEMORY_BYTES    = 4096;
    localparam int SCREEN_WIDTH    = 64;
    localparam int SCREEN_HEIGHT   = 32;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int ADDR_W          = $clog2(MEMORY_BYTES);
    localparam int ROW_W           = $clog2(SCREEN_HEIGHT);
    localparam int FONT_BYTES      = 80;
    localparam logic [ADDR_W-1:0] START_ADDR_RST = ADDR_W'(512);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_OP    = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // opcode groups (top nibble)
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEQ  = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SREQ = 4'h5;
    localparam logic [3:0] OP_LDV  = 4'h6;
    localparam logic [3:0] OP_ADDV = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SRNE = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    // low byte codes
    localparam logic [7:0] NN_CLS     = 8'hE0;
    localparam logic [7:0] NN_RET     = 8'hEE;
    localparam logic [7:0] NN_SKP     = 8'h9E;
    localparam logic [7:0] NN_SKNP    = 8'hA1;
    localparam logic [7:0] NN_GETDLY  = 8'h07;
    localparam logic [7:0] NN_WAITKEY = 8'h0A;
    localparam logic [7:0] NN_SETDLY  = 8'h15;
    localparam logic [7:0] NN_SETSND  = 8'h18;
    localparam logic [7:0] NN_ADDI    = 8'h1E;
    localparam logic [7:0] NN_FONT    = 8'h29;
    localparam logic [7:0] NN_BCD     = 8'h33;
    localparam logic [7:0] NN_STORE   = 8'h55;
    localparam logic [7:0] NN_LOAD    = 8'h65;

    // 8XYN alu codes
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [3:0] REG_VF = 4'hF;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_ROW, S_F1, S_F2, S_RX, S_RY, S_R0, S_EXEC, S_RET,
        S_W2, S_BCD1, S_BCD2, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR,
        S_D_RD, S_D_WR, S_D_FIN, S_FIN
    } t_state;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
        8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
        8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
        8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
        8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
        8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
        8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
        8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
    };

    // initial memory contents: font glyphs, zero above them
    function automatic logic [7:0] init_byte(input logic [ADDR_W-1:0] a);
        logic [7:0] b;
        b = 8'h00;
        if (a < ADDR_W'(FONT_BYTES)) begin
            b = FONT[a[6:0]];
        end
        return b;
    endfunction

endpackage

### rtl/chip8_cpu_core.sv
// chip8 machine core: memories, fetch/execute sequencer and display
//
// channel   direction  signals                                  handshake
// command   in         i_mode .. i_row_select                   start && !busy
// result    out        o_status .. o_row_pixels                 o_done, one cycle
// config    in         i_cfg_data                               i_cfg_we
//
// load and idle beats are done from the idle state, a display read passes through S_ROW;
// a run beat fetches two bytes, reads vx, vy and v0, executes and finishes; FX55/FX65
// add a read and a write step per byte; draw adds a read and a write step per sprite row
// after reset a pass over every address loads the font and clears memory;
// busy is high meanwhile; results cannot be held off by the receiver
module chip8_cpu_core
    import c8_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_mode,
    input  logic [ADDR_W-1:0]         i_load_address,
    input  logic [7:0]                i_load_byte,
    input  logic                      i_key_down,
    input  logic [3:0]                i_key_code,
    input  logic [7:0]                i_random_byte,
    input  logic [ROW_W-1:0]          i_row_select,
    input  logic                      i_cfg_we,
    input  logic [ADDR_W-1:0]         i_cfg_data,
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic                      o_halted_flag,
    output logic                      o_screen_changed,
    output logic                      o_sound_on,
    output logic [ADDR_W-1:0]         o_pc_value,
    output logic [SCREEN_WIDTH-1:0]   o_row_pixels
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SI_W = $clog2(STACK_DEPTH);

    // memories
    logic [7:0]              mem [MEMORY_BYTES];
    logic [7:0]              rf [16];
    logic [ADDR_W-1:0]       stk [STACK_DEPTH];
    logic [SCREEN_WIDTH-1:0] fb [SCREEN_HEIGHT];

    logic [ADDR_W-1:0]       mem_addr;
    logic                    mem_we;
    logic [7:0]              mem_wd;
    logic [7:0]              r_mem_q;
    logic [3:0]              rf_addr;
    logic                    rf_we;
    logic [7:0]              rf_wd;
    logic [7:0]              r_rf_q;
    logic [SI_W-1:0]         st_addr;
    logic                    st_we;
    logic [ADDR_W-1:0]       r_st_q;
    logic [ROW_W-1:0]        fb_addr;
    logic                    fb_we;
    logic [SCREEN_WIDTH-1:0] fb_wd;
    logic [SCREEN_WIDTH-1:0] r_fb_q;
    logic                    r_fb_vq;
    logic [SCREEN_HEIGHT-1:0] r_fb_valid;
    logic                    fb_clear;

    // control and datapath registers
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [ADDR_W-1:0] r_start_addr;
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic [15:0]       r_idx, n_idx;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [7:0]        r_dly, n_dly;
    logic [7:0]        r_snd, n_snd;
    logic              r_halt, n_halt;
    logic [15:0]       r_op, n_op;
    logic [7:0]        r_vx, n_vx;
    logic [7:0]        r_vy, n_vy;
    logic [7:0]        r_v0, n_v0;
    logic [3:0]        r_cnt, n_cnt;
    logic              r_coll, n_coll;
    t_status           r_stat, n_stat;
    logic              r_chg, n_chg;
    logic              r_key_down, n_key_down;
    logic [3:0]        r_key_code, n_key_code;
    logic [7:0]        r_rnd, n_rnd;
    logic [3:0]        r_w2_addr, n_w2_addr;
    logic [7:0]        r_w2_data, n_w2_data;
    logic [3:0]        r_bcd_t, n_bcd_t;
    logic [3:0]        r_bcd_o, n_bcd_o;

    logic                    r_done, n_done;
    logic [1:0]              r_o_status, n_o_status;
    logic                    r_o_halt, n_o_halt;
    logic                    r_o_chg, n_o_chg;
    logic                    r_o_snd, n_o_snd;
    logic [ADDR_W-1:0]       r_o_pc, n_o_pc;
    logic [SCREEN_WIDTH-1:0] r_o_row, n_o_row;

    // decode fields
    logic [3:0]        op_g, op_x, op_y, op_n;
    logic [7:0]        op_nn;
    logic [ADDR_W-1:0] op_nnn;
    assign op_g   = r_op[15:12];
    assign op_x   = r_op[11:8];
    assign op_y   = r_op[7:4];
    assign op_n   = r_op[3:0];
    assign op_nn  = r_op[7:0];
    assign op_nnn = r_op[ADDR_W-1:0];

    logic [8:0]        sum9;
    logic [ADDR_W-1:0] idx_off;
    logic [SP_W-1:0]   sp_dec;
    logic              key_hit;
    logic [7:0]        tick_dly, tick_snd;
    assign sum9     = {1'b0, r_vx} + {1'b0, r_vy};
    assign idx_off  = r_idx[ADDR_W-1:0] + ADDR_W'(r_cnt);
    assign sp_dec   = r_sp - SP_W'(1);
    assign key_hit  = r_key_down && (r_vx == {4'h0, r_key_code});
    assign tick_dly = (r_dly != 8'd0) ? r_dly - 8'd1 : r_dly;
    assign tick_snd = (r_snd != 8'd0) ? r_snd - 8'd1 : r_snd;

    // bcd digits via reciprocal multiply
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t;
    logic [6:0]  bcd_o;
    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h = 2'd2;
        end else if (r_vx >= 8'd100) begin
            bcd_h = 2'd1;
        end else begin
            bcd_h = 2'd0;
        end
        bcd_rem  = 7'(r_vx - 8'(bcd_h) * 8'd100);
        bcd_prod = 15'(bcd_rem) * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = bcd_rem - 7'(bcd_t) * 7'd10;
    end

    // sprite row: vf is live while drawing, so x or y equal to F see the collision flag
    logic [ROW_W-1:0]        drw_row;
    logic [SCREEN_WIDTH-1:0] drw_old, drw_base, drw_spr;
    logic [2*SCREEN_WIDTH-1:0] drw_dbl;
    logic [7:0]              drw_hit8, drw_mask;
    logic                    drw_found;
    assign drw_row  = (op_y == REG_VF) ? ROW_W'(r_coll) + ROW_W'(r_cnt)
                                       : r_vy[ROW_W-1:0] + ROW_W'(r_cnt);
    assign drw_old  = r_fb_vq ? r_fb_q : '0;
    assign drw_base = {r_mem_q, {(SCREEN_WIDTH-8){1'b0}}};
    assign drw_dbl  = {drw_base, drw_base} >> r_vx[5:0];
    assign drw_hit8 = r_mem_q & drw_old[SCREEN_WIDTH-1 -: 8];

    always_comb begin
        drw_found = 1'b0;
        drw_mask  = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            if (!drw_found) begin
                drw_mask[i] = 1'b1;
            end
            if (drw_hit8[i]) begin
                drw_found = 1'b1;
            end
        end
        if (op_x != REG_VF) begin
            drw_spr = drw_dbl[SCREEN_WIDTH-1:0];
        end else if (r_coll || !drw_found) begin
            drw_spr = r_coll ? (drw_base >> 1) : drw_base;
        end else begin
            // pixels after the first collision move one column right
            drw_spr = {r_mem_q & drw_mask, {(SCREEN_WIDTH-8){1'b0}}}
                    | ({r_mem_q & ~drw_mask, {(SCREEN_WIDTH-8){1'b0}}} >> 1);
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_mem_q <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf[rf_addr] <= rf_wd;
        end
        r_rf_q <= rf[rf_addr];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            stk[st_addr] <= r_pc;
        end
        r_st_q <= stk[st_addr];
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            fb[fb_addr] <= fb_wd;
        end
        r_fb_q  <= fb[fb_addr];
        r_fb_vq <= r_fb_valid[fb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || fb_clear) begin
            r_fb_valid <= '0;
        end else if (fb_we) begin
            r_fb_valid[fb_addr] <= 1'b1;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_start_addr <= START_ADDR_RST;
            r_pc         <= START_ADDR_RST;
            r_idx        <= '0;
            r_sp         <= '0;
            r_dly        <= '0;
            r_snd        <= '0;
            r_halt       <= 1'b0;
            r_done       <= 1'b0;
            r_stat       <= ST_OK;
            r_cnt        <= '0;
            r_coll       <= 1'b0;
            r_chg        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_cfg_we) begin
                r_start_addr <= i_cfg_data;
            end
            r_pc   <= n_pc;
            r_idx  <= n_idx;
            r_sp   <= n_sp;
            r_dly  <= n_dly;
            r_snd  <= n_snd;
            r_halt <= n_halt;
            r_done <= n_done;
            r_stat <= n_stat;
            r_cnt  <= n_cnt;
            r_coll <= n_coll;
            r_chg  <= n_chg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_vx       <= n_vx;
        r_vy       <= n_vy;
        r_v0       <= n_v0;
        r_key_down <= n_key_down;
        r_key_code <= n_key_code;
        r_rnd      <= n_rnd;
        r_w2_addr  <= n_w2_addr;
        r_w2_data  <= n_w2_data;
        r_bcd_t    <= n_bcd_t;
        r_bcd_o    <= n_bcd_o;
        r_o_status <= n_o_status;
        r_o_halt   <= n_o_halt;
        r_o_chg    <= n_o_chg;
        r_o_snd    <= n_o_snd;
        r_o_pc     <= n_o_pc;
        r_o_row    <= n_o_row;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_pc       = r_pc;
        n_idx      = r_idx;
        n_sp       = r_sp;
        n_dly      = r_dly;
        n_snd      = r_snd;
        n_halt     = r_halt;
        n_op       = r_op;
        n_vx       = r_vx;
        n_vy       = r_vy;
        n_v0       = r_v0;
        n_cnt      = r_cnt;
        n_coll     = r_coll;
        n_stat     = r_stat;
        n_chg      = r_chg;
        n_key_down = r_key_down;
        n_key_code = r_key_code;
        n_rnd      = r_rnd;
        n_w2_addr  = r_w2_addr;
        n_w2_data  = r_w2_data;
        n_bcd_t    = r_bcd_t;
        n_bcd_o    = r_bcd_o;
        n_done     = 1'b0;
        n_o_status = ST_OK;
        n_o_halt   = r_halt;
        n_o_chg    = 1'b0;
        n_o_snd    = (r_snd != 8'd0);
        n_o_pc     = r_pc;
        n_o_row    = '0;
        mem_addr   = r_pc;
        mem_we     = 1'b0;
        mem_wd     = r_vx;
        rf_addr    = op_x;
        rf_we      = 1'b0;
        rf_wd      = r_vx;
        st_addr    = r_sp[SI_W-1:0];
        st_we      = 1'b0;
        fb_addr    = i_row_select;
        fb_we      = 1'b0;
        fb_wd      = drw_old ^ drw_spr;
        fb_clear   = 1'b0;

        case (r_state)
            S_CLR: begin
                mem_addr = r_clr;
                mem_we   = 1'b1;
                mem_wd   = init_byte(r_clr);
                // register file is zeroed during the same pass
                rf_addr  = r_clr[3:0];
                rf_we    = 1'b1;
                rf_wd    = 8'h00;
                n_clr    = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_key_down = i_key_down;
                    n_key_code = i_key_code;
                    n_rnd      = i_random_byte;
                    n_stat     = ST_OK;
                    n_chg      = 1'b0;
                    if (i_mode == MODE_LOAD) begin
                        mem_addr = i_load_address;
                        mem_we   = 1'b1;
                        mem_wd   = i_load_byte;
                        n_done   = 1'b1;
                    end else if (i_mode == MODE_READ) begin
                        n_state = S_ROW;
                    end else if (i_mode == MODE_RUN && !r_halt) begin
                        n_state = S_F1;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            S_ROW: begin
                n_o_row = r_fb_vq ? r_fb_q : '0;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_F1: begin
                n_op[15:8] = r_mem_q;
                mem_addr   = r_pc + ADDR_W'(1);
                n_state    = S_F2;
            end
            S_F2: begin
                n_op[7:0] = r_mem_q;
                n_pc      = r_pc + ADDR_W'(2);
                rf_addr   = r_op[11:8];
                n_state   = S_RX;
            end
            S_RX: begin
                n_vx    = r_rf_q;
                rf_addr = op_y;
                n_state = S_RY;
            end
            S_RY: begin
                n_vy    = r_rf_q;
                rf_addr = 4'h0;
                n_state = S_R0;
            end
            S_R0: begin
                n_v0    = r_rf_q;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_FIN;
                case (op_g)
                    OP_SYS: begin
                        if (op_x == 4'h0 && op_nn == NN_CLS) begin
                            fb_clear = 1'b1;
                            n_chg    = 1'b1;
                        end else if (op_x == 4'h0 && op_nn == NN_RET) begin
                            if (r_sp == '0) begin
                                n_stat = ST_UNDERFLOW;
                            end else begin
                                n_sp    = sp_dec;
                                st_addr = sp_dec[SI_W-1:0];
                                n_state = S_RET;
                            end
                        end else begin
                            n_stat = ST_BAD_OP;
                        end
                    end
                    OP_JP: n_pc = op_nnn;
                    OP_CALL: begin
                        if (r_sp < SP_W'(STACK_DEPTH)) begin
                            st_we = 1'b1;
                            n_sp  = r_sp + SP_W'(1);
                        end
                        n_pc = op_nnn;
                    end
                    OP_SEQ: begin
                        if (r_vx == op_nn) begin
                            n_pc = r_pc + ADDR_W'(2);
                        end
                    end
                    OP_SNE: begin
                        if (r_vx != op_nn) begin
                            n_pc = r_pc + ADDR_W'(2);
                        end
                    end
                    OP_SREQ: begin
                        if (op_n != 4'h0) begin
                            n_stat = ST_BAD_OP;
                        end else if (r_vx == r_vy) begin
                            n_pc = r_pc + ADDR_W'(2);
                        end
                    end
                    OP_SRNE: begin
                        if (op_n != 4'h0) begin
                            n_stat = ST_BAD_OP;
                        end else if (r_vx != r_vy) begin
                            n_pc = r_pc + ADDR_W'(2);
                        end
                    end
                    OP_LDV: begin
                        rf_we = 1'b1;
                        rf_wd = op_nn;
                    end
                    OP_ADDV: begin
                        rf_we = 1'b1;
                        rf_wd = r_vx + op_nn;
                    end
                    OP_ALU: begin
                        rf_we     = 1'b1;
                        n_w2_addr = op_x;
                        case (op_n)
                            ALU_MOV: rf_wd = r_vy;
                            ALU_OR:  rf_wd = r_vx | r_vy;
                            ALU_AND: rf_wd = r_vx & r_vy;
                            ALU_XOR: rf_wd = r_vx ^ r_vy;
                            ALU_ADD: begin
                                // flag first, then the sum
                                rf_addr   = REG_VF;
                                rf_wd     = {7'h00, sum9[8]};
                                n_w2_data = sum9[7:0];
                                n_state   = S_W2;
                            end
                            ALU_SUB: begin
                                rf_addr   = REG_VF;
                                rf_wd     = {7'h00, (r_vx > r_vy)};
                                n_w2_data = r_vx - r_vy;
                                n_state   = S_W2;
                            end
                            ALU_SUBN: begin
                                rf_addr   = REG_VF;
                                rf_wd     = {7'h00, (r_vy > r_vx)};
                                n_w2_data = r_vy - r_vx;
                                n_state   = S_W2;
                            end
                            ALU_SHR: begin
                                // shifted value lands last, so x equal to F keeps it
                                rf_addr   = REG_VF;
                                rf_wd     = {7'h00, r_vy[0]};
                                n_w2_data = {1'b0, r_vy[7:1]};
                                n_state   = S_W2;
                            end
                            ALU_SHL: begin
                                rf_addr   = REG_VF;
                                rf_wd     = {7'h00, r_vy[7]};
                                n_w2_data = {r_vy[6:0], 1'b0};
                                n_state   = S_W2;
                            end
                            default: begin
                                rf_we  = 1'b0;
                                n_stat = ST_BAD_OP;
                            end
                        endcase
                    end
                    OP_LDI:  n_idx = {4'h0, op_nnn};
                    OP_JPV0: n_pc  = op_nnn + ADDR_W'(r_v0);
                    OP_RND: begin
                        rf_we = 1'b1;
                        rf_wd = r_rnd & op_nn;
                    end
                    OP_DRW: begin
                        n_cnt  = '0;
                        n_coll = 1'b0;
                        n_chg  = 1'b1;
                        n_state = (op_n == 4'h0) ? S_D_FIN : S_D_RD;
                    end
                    OP_KEY: begin
                        if (op_nn == NN_SKP) begin
                            if (key_hit) begin
                                n_pc = r_pc + ADDR_W'(2);
                            end
                        end else if (op_nn == NN_SKNP) begin
                            if (!key_hit) begin
                                n_pc = r_pc + ADDR_W'(2);
                            end
                        end else begin
                            n_stat = ST_BAD_OP;
                        end
                    end
                    OP_MISC: begin
                        case (op_nn)
                            NN_GETDLY: begin
                                rf_we = 1'b1;
                                rf_wd = r_dly;
                            end
                            NN_SETDLY: n_dly = r_vx;
                            NN_SETSND: n_snd = r_vx;
                            NN_ADDI:   n_idx = r_idx + 16'(r_vx);
                            NN_WAITKEY: begin
                                if (!r_key_down) begin
                                    n_pc = r_pc - ADDR_W'(2);
                                end else begin
                                    rf_we = 1'b1;
                                    rf_wd = {4'h0, r_key_code};
                                end
                            end
                            NN_FONT: n_idx = 16'(r_vx) * 16'd5;
                            NN_BCD: begin
                                mem_addr = r_idx[ADDR_W-1:0];
                                mem_we   = 1'b1;
                                mem_wd   = {6'h00, bcd_h};
                                n_bcd_t  = bcd_t;
                                n_bcd_o  = bcd_o[3:0];
                                n_state  = S_BCD1;
                            end
                            NN_STORE: begin
                                n_cnt   = '0;
                                n_state = S_ST_RD;
                            end
                            NN_LOAD: begin
                                n_cnt   = '0;
                                n_state = S_LD_RD;
                            end
                            default: n_stat = ST_BAD_OP;
                        endcase
                    end
                    default: n_stat = ST_BAD_OP;
                endcase
            end
            S_RET: begin
                n_pc    = r_st_q;
                n_state = S_FIN;
            end
            S_W2: begin
                rf_addr = r_w2_addr;
                rf_we   = 1'b1;
                rf_wd   = r_w2_data;
                n_state = S_FIN;
            end
            S_BCD1: begin
                mem_addr = r_idx[ADDR_W-1:0] + ADDR_W'(1);
                mem_we   = 1'b1;
                mem_wd   = {4'h0, r_bcd_t};
                n_state  = S_BCD2;
            end
            S_BCD2: begin
                mem_addr = r_idx[ADDR_W-1:0] + ADDR_W'(2);
                mem_we   = 1'b1;
                mem_wd   = {4'h0, r_bcd_o};
                n_state  = S_FIN;
            end
            S_ST_RD: begin
                rf_addr = r_cnt;
                n_state = S_ST_WR;
            end
            S_ST_WR: begin
                mem_addr = idx_off;
                mem_we   = 1'b1;
                mem_wd   = r_rf_q;
                n_cnt    = r_cnt + 4'd1;
                n_state  = (r_cnt == op_x) ? S_FIN : S_ST_RD;
            end
            S_LD_RD: begin
                mem_addr = idx_off;
                n_state  = S_LD_WR;
            end
            S_LD_WR: begin
                rf_addr = r_cnt;
                rf_we   = 1'b1;
                rf_wd   = r_mem_q;
                n_cnt   = r_cnt + 4'd1;
                n_state = (r_cnt == op_x) ? S_FIN : S_LD_RD;
            end
            S_D_RD: begin
                mem_addr = idx_off;
                fb_addr  = drw_row;
                n_state  = S_D_WR;
            end
            S_D_WR: begin
                fb_addr = drw_row;
                fb_we   = 1'b1;
                n_coll  = r_coll || ((drw_old & drw_spr) != '0);
                n_cnt   = r_cnt + 4'd1;
                n_state = (r_cnt == op_n - 4'd1) ? S_D_FIN : S_D_RD;
            end
            S_D_FIN: begin
                rf_addr = REG_VF;
                rf_we   = 1'b1;
                rf_wd   = {7'h00, r_coll};
                n_state = S_FIN;
            end
            S_FIN: begin
                n_done     = 1'b1;
                n_o_status = r_stat;
                n_o_chg    = r_chg;
                n_state    = S_IDLE;
                if (r_stat != ST_OK) begin
                    n_halt   = 1'b1;
                    n_o_halt = 1'b1;
                end else begin
                    n_dly   = tick_dly;
                    n_snd   = tick_snd;
                    n_o_snd = (tick_snd != 8'd0);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_o_status;
    assign o_halted_flag    = r_o_halt;
    assign o_screen_changed = r_o_chg;
    assign o_sound_on       = r_o_snd;
    assign o_pc_value       = r_o_pc;
    assign o_row_pixels     = r_o_row;

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> o_halted_flag)
        else $error("error result without halt");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt cleared without reset");

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_reset_pc: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_pc == r_start_addr))
        else $error("pc not at start address after reset");

    a_row_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_screen_changed) |-> (o_row_pixels == '0))
        else $error("row data on a drawing beat");

endmodule

### bench/chip8_cpu_core_tb.sv
// self-checking testbench for the chip8 machine core
`timescale 1ns / 100ps

module chip8_cpu_core_tb;
    import c8_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int         RUN_LIMIT = 400000;
    localparam int         STK_DEPTH = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic        halted;
        logic        changed;
        logic        sound;
        logic [11:0] pc;
        logic [63:0] row;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0]  i_mode = MODE_NONE;
    logic [11:0] i_load_address = '0;
    logic [7:0]  i_load_byte = '0;
    logic        i_key_down = 1'b0;
    logic [3:0]  i_key_code = '0;
    logic [7:0]  i_random_byte = '0;
    logic [4:0]  i_row_select = '0;
    logic        i_cfg_we = 1'b0;
    logic [11:0] i_cfg_data = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_halted_flag;
    logic        o_screen_changed;
    logic        o_sound_on;
    logic [11:0] o_pc_value;
    logic [63:0] o_row_pixels;

    // machine image kept by the predictor
    logic [7:0]  mem_img [MEMORY_BYTES];
    logic [63:0] screen [SCREEN_HEIGHT];
    logic [7:0]  vreg [16];
    logic [15:0] ireg;
    logic [11:0] pc;
    logic [11:0] ret_stack [STK_DEPTH];
    int          sp;
    logic [7:0]  dly, snd;
    logic        halted;

    t_result result_q [$];
    int      errors = 0;
    int      cycles = 0;
    int      idle_pct = 0;
    int      beats = 0;

    chip8_cpu_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_load_address(i_load_address), .i_load_byte(i_load_byte),
        .i_key_down(i_key_down), .i_key_code(i_key_code),
        .i_random_byte(i_random_byte), .i_row_select(i_row_select),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_status(o_status), .o_halted_flag(o_halted_flag),
        .o_screen_changed(o_screen_changed), .o_sound_on(o_sound_on),
        .o_pc_value(o_pc_value), .o_row_pixels(o_row_pixels)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result checker, one beat per o_done
    always @(posedge i_clk) begin
        t_result want;
        if (o_done) begin
            if (result_q.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
            end else begin
                want = result_q.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, o_status);
                    errors++;
                end
                if (o_halted_flag !== want.halted) begin
                    $display("%0t: halted expected %0d got %0d", $time, want.halted,
                             o_halted_flag);
                    errors++;
                end
                if (o_screen_changed !== want.changed) begin
                    $display("%0t: screen_changed expected %0d got %0d", $time, want.changed,
                             o_screen_changed);
                    errors++;
                end
                if (o_sound_on !== want.sound) begin
                    $display("%0t: sound_on expected %0d got %0d", $time, want.sound,
                             o_sound_on);
                    errors++;
                end
                if (o_pc_value !== want.pc) begin
                    $display("%0t: pc expected %h got %h", $time, want.pc, o_pc_value);
                    errors++;
                end
                if (o_row_pixels !== want.row) begin
                    $display("%0t: row expected %h got %h", $time, want.row, o_row_pixels);
                    errors++;
                end
            end
        end
    end

    task automatic machine_reset();
        for (int a = 0; a < MEMORY_BYTES; a++)
            mem_img[a] = (a < FONT_BYTES) ? FONT[a] : 8'h00;
        for (int r = 0; r < SCREEN_HEIGHT; r++) screen[r] = '0;
        for (int r = 0; r < 16; r++) vreg[r] = '0;
        for (int r = 0; r < STK_DEPTH; r++) ret_stack[r] = '0;
        ireg = '0;
        pc = START_ADDR_RST;
        sp = 0;
        dly = '0;
        snd = '0;
        halted = 1'b0;
    endtask

    task automatic draw_sprite(input logic [3:0] x, input logic [3:0] y, input logic [3:0] n);
        logic [7:0]  line;
        logic [11:0] a;
        int          py, px;
        vreg[REG_VF] = 8'h00;
        for (int dy = 0; dy < n; dy++) begin
            a = ireg[11:0] + 12'(dy);
            line = mem_img[a];
            py = (int'(vreg[y]) + dy) % SCREEN_HEIGHT;
            for (int dx = 0; dx < 8; dx++) begin
                if (line[7-dx]) begin
                    px = (int'(vreg[x]) + dx) % SCREEN_WIDTH;
                    if (screen[py][63-px]) vreg[REG_VF] = 8'h01;
                    screen[py][63-px] = ~screen[py][63-px];
                end
            end
        end
    endtask

    task automatic execute_op(input logic [15:0] op, input logic kd, input logic [3:0] kc,
                              input logic [7:0] rb, output t_status st, output logic chg);
        logic [3:0]  x, y, n;
        logic [7:0]  nn, a, b;
        logic [11:0] nnn, ad;
        logic        hit;
        x = op[11:8]; y = op[7:4]; n = op[3:0];
        nn = op[7:0]; nnn = op[11:0];
        a = vreg[x]; b = vreg[y];
        st = ST_OK;
        chg = 1'b0;
        case (op[15:12])
            OP_SYS: begin
                if (x == 4'h0 && nn == NN_CLS) begin
                    for (int r = 0; r < SCREEN_HEIGHT; r++) screen[r] = '0;
                    chg = 1'b1;
                end else if (x == 4'h0 && nn == NN_RET) begin
                    if (sp == 0) st = ST_UNDERFLOW;
                    else begin
                        sp--;
                        pc = ret_stack[sp];
                    end
                end else st = ST_BAD_OP;
            end
            OP_JP:   pc = nnn;
            OP_CALL: begin
                if (sp < STK_DEPTH) begin
                    ret_stack[sp] = pc;
                    sp++;
                end
                pc = nnn;
            end
            OP_SEQ:  if (a == nn) pc = pc + 12'd2;
            OP_SNE:  if (a != nn) pc = pc + 12'd2;
            OP_SREQ: if (n != 4'h0) st = ST_BAD_OP; else if (a == b) pc = pc + 12'd2;
            OP_SRNE: if (n != 4'h0) st = ST_BAD_OP; else if (a != b) pc = pc + 12'd2;
            OP_LDV:  vreg[x] = nn;
            OP_ADDV: vreg[x] = a + nn;
            OP_ALU: begin
                case (n)
                    ALU_MOV: vreg[x] = b;
                    ALU_OR:  vreg[x] = a | b;
                    ALU_AND: vreg[x] = a & b;
                    ALU_XOR: vreg[x] = a ^ b;
                    ALU_ADD: begin
                        vreg[REG_VF] = ({1'b0, a} + {1'b0, b} > 9'd255) ? 8'd1 : 8'd0;
                        vreg[x] = a + b;
                    end
                    ALU_SUB: begin
                        vreg[REG_VF] = (a > b) ? 8'd1 : 8'd0;
                        vreg[x] = a - b;
                    end
                    ALU_SUBN: begin
                        vreg[REG_VF] = (b > a) ? 8'd1 : 8'd0;
                        vreg[x] = b - a;
                    end
                    // vx takes vy first, flag lands after it
                    ALU_SHR: begin
                        vreg[x] = b;
                        vreg[REG_VF] = {7'd0, b[0]};
                        vreg[x] = b >> 1;
                    end
                    ALU_SHL: begin
                        vreg[x] = b;
                        vreg[REG_VF] = {7'd0, b[7]};
                        vreg[x] = b << 1;
                    end
                    default: st = ST_BAD_OP;
                endcase
            end
            OP_LDI:  ireg = {4'h0, nnn};
            OP_JPV0: pc = nnn + {4'h0, vreg[0]};
            OP_RND:  vreg[x] = rb & nn;
            OP_DRW: begin
                draw_sprite(x, y, n);
                chg = 1'b1;
            end
            OP_KEY: begin
                hit = kd && (a == {4'h0, kc});
                if (nn == NN_SKP) begin
                    if (hit) pc = pc + 12'd2;
                end else if (nn == NN_SKNP) begin
                    if (!hit) pc = pc + 12'd2;
                end else st = ST_BAD_OP;
            end
            default: begin
                case (nn)
                    NN_GETDLY:  vreg[x] = dly;
                    NN_SETDLY:  dly = a;
                    NN_SETSND:  snd = a;
                    NN_ADDI:    ireg = ireg + {8'h00, a};
                    NN_WAITKEY: if (!kd) pc = pc - 12'd2; else vreg[x] = {4'h0, kc};
                    NN_FONT:    ireg = 16'(a) * 16'd5;
                    NN_BCD: begin
                        ad = ireg[11:0];
                        mem_img[ad] = a / 100;
                        mem_img[ad + 12'd1] = (a / 10) % 10;
                        mem_img[ad + 12'd2] = a % 10;
                    end
                    NN_STORE:
                        for (int i = 0; i <= x; i++) mem_img[ireg[11:0] + 12'(i)] = vreg[i];
                    NN_LOAD:
                        for (int i = 0; i <= x; i++) vreg[i] = mem_img[ireg[11:0] + 12'(i)];
                    default: st = ST_BAD_OP;
                endcase
            end
        endcase
    endtask

    // expected result of one accepted beat
    task automatic machine_step(input logic [1:0] mode, input logic [11:0] la,
                                input logic [7:0] lb, input logic kd, input logic [3:0] kc,
                                input logic [7:0] rb, input logic [4:0] rs);
        t_result    res;
        t_status    st;
        logic       chg;
        logic [15:0] op;
        res = '0;
        if (mode == MODE_LOAD) begin
            mem_img[la] = lb;
        end else if (mode == MODE_RUN && !halted) begin
            op = {mem_img[pc], mem_img[pc + 12'd1]};
            pc = pc + 12'd2;
            execute_op(op, kd, kc, rb, st, chg);
            res.status = st;
            res.changed = chg;
            if (st != ST_OK) halted = 1'b1;
            else begin
                if (dly != 0) dly--;
                if (snd != 0) snd--;
            end
        end else if (mode == MODE_READ) begin
            res.row = screen[rs];
        end
        res.halted = halted;
        res.sound = (snd != 0);
        res.pc = pc;
        result_q.push_back(res);
    endtask

    task automatic send_beat(input logic [1:0] mode, input logic [11:0] la,
                             input logic [7:0] lb, input logic kd, input logic [3:0] kc,
                             input logic [7:0] rb, input logic [4:0] rs);
        start <= 1'b1;
        i_mode <= mode;
        i_load_address <= la;
        i_load_byte <= lb;
        i_key_down <= kd;
        i_key_code <= kc;
        i_random_byte <= rb;
        i_row_select <= rs;
        do @(posedge i_clk); while (busy);
        machine_step(mode, la, lb, kd, kc, rb, rs);
        beats++;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // place the instruction at the current pc, then run it
    task automatic run_op(input logic [15:0] op, input logic kd, input logic [3:0] kc,
                          input logic [7:0] rb);
        logic [11:0] at;
        at = pc;
        send_beat(MODE_LOAD, at, op[15:8], 1'($urandom), 4'($urandom), 8'($urandom),
                  5'($urandom));
        send_beat(MODE_LOAD, at + 12'd1, op[7:0], 1'($urandom), 4'($urandom), 8'($urandom),
                  5'($urandom));
        send_beat(MODE_RUN, 12'($urandom), 8'($urandom), kd, kc, rb, 5'($urandom));
    endtask

    task automatic run_rand_keys(input logic [15:0] op);
        logic [3:0] kc;
        kc = $urandom_range(0, 1) ? vreg[op[11:8]][3:0] : 4'($urandom);
        run_op(op, 1'($urandom), kc, 8'($urandom));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_start_addr(input logic [11:0] v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_op();
        logic [3:0]  grp, x, y;
        logic [7:0]  nn;
        logic [3:0]  alu_codes [9];
        logic [7:0]  misc_codes [9];
        logic [15:0] op;
        alu_codes = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                      ALU_SUBN, ALU_SHL};
        misc_codes = '{NN_GETDLY, NN_WAITKEY, NN_SETDLY, NN_SETSND, NN_ADDI, NN_FONT,
                       NN_BCD, NN_STORE, NN_LOAD};
        grp = 4'($urandom);
        x = 4'($urandom);
        y = 4'($urandom);
        nn = 8'($urandom);
        case (grp)
            OP_SYS:  op = {OP_SYS, 4'h0, (sp > 0 && $urandom_range(0, 2) != 0) ? NN_RET : NN_CLS};
            OP_SEQ, OP_SNE: op = {grp, x, $urandom_range(0, 1) ? vreg[x] : nn};
            OP_SREQ, OP_SRNE: op = {grp, x, y, 4'h0};
            OP_ALU:  op = {grp, x, y, alu_codes[$urandom_range(0, 8)]};
            OP_KEY:  op = {grp, x, $urandom_range(0, 1) ? NN_SKP : NN_SKNP};
            OP_MISC: op = {grp, x, misc_codes[$urandom_range(0, 8)]};
            default: op = {grp, x, nn};
        endcase
        return op;
    endfunction

    task automatic test_directed();
        send_beat(MODE_NONE, 12'hFFF, 8'hFF, 1'b1, 4'hF, 8'hFF, 5'd31);
        send_beat(MODE_READ, '0, '0, 1'b0, '0, '0, 5'd0);
        run_op({OP_LDV, 4'h0, 8'hFF}, 0, 0, 0);
        run_op({OP_LDV, 4'h1, 8'h01}, 0, 0, 0);
        run_op({OP_ALU, 4'h0, 4'h1, ALU_ADD}, 0, 0, 0);     // carry out of 255
        run_op({OP_ALU, 4'hF, 4'h1, ALU_SUB}, 0, 0, 0);     // flag then result into vf
        run_op({OP_ALU, 4'h2, 4'h0, ALU_SUBN}, 0, 0, 0);
        run_op({OP_ALU, 4'hF, 4'h1, ALU_SHL}, 0, 0, 0);
        run_op({OP_ALU, 4'h3, 4'h1, ALU_SHR}, 0, 0, 0);
        run_op({OP_LDV, 4'h0, 8'd199}, 0, 0, 0);
        run_op({OP_LDI, 12'hFFF}, 0, 0, 0);
        run_op({OP_MISC, 4'h0, NN_BCD}, 0, 0, 0);           // digits wrap past top
        run_op({OP_MISC, 4'hF, NN_STORE}, 0, 0, 0);
        run_op({OP_MISC, 4'hF, NN_LOAD}, 0, 0, 0);
        run_op({OP_MISC, 4'h5, NN_WAITKEY}, 1'b0, 4'h3, 0);
        run_op({OP_MISC, 4'h5, NN_WAITKEY}, 1'b1, 4'hF, 0);
        run_op({OP_KEY, 4'h5, NN_SKP}, 1'b1, 4'hF, 0);
        run_op({OP_KEY, 4'h5, NN_SKNP}, 1'b1, 4'hF, 0);
        run_op({OP_RND, 4'h6, 8'h5A}, 0, 0, 8'hFF);
        run_op({OP_LDV, 4'h7, 8'd62}, 0, 0, 0);
        run_op({OP_LDV, 4'h8, 8'd30}, 0, 0, 0);
        run_op({OP_MISC, 4'h0, NN_FONT}, 0, 0, 0);
        run_op({OP_DRW, 4'h7, 4'h8, 4'hF}, 0, 0, 0);        // wraps both ways
        run_op({OP_DRW, 4'h7, 4'h8, 4'hF}, 0, 0, 0);        // full collision
        send_beat(MODE_READ, '0, '0, 1'b0, '0, '0, 5'd31);
        run_op({OP_MISC, 4'h0, NN_SETSND}, 0, 0, 0);
        run_op({OP_MISC, 4'h0, NN_SETDLY}, 0, 0, 0);
        run_op({OP_MISC, 4'h9, NN_GETDLY}, 0, 0, 0);
        run_op({OP_SYS, 4'h0, NN_CLS}, 0, 0, 0);
        run_op({OP_JP, 12'hFFE}, 0, 0, 0);                  // next instruction fills the top two bytes
        run_op({OP_CALL, 12'h300}, 0, 0, 0);
        run_op({OP_SYS, 4'h0, NN_RET}, 0, 0, 0);
        run_op({OP_JPV0, 12'hFFF}, 0, 0, 0);
    endtask

    task automatic test_stack_full();
        for (int i = 0; i < STK_DEPTH + 2; i++) run_op({OP_CALL, 12'($urandom)}, 0, 0, 0);
        while (sp > 0) run_op({OP_SYS, 4'h0, NN_RET}, 0, 0, 0);
    endtask

    task automatic test_random(input int pct, input int count);
        int stop_at;
        int pick;
        idle_pct = pct;
        stop_at = beats + count;
        while (beats < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) run_rand_keys(rand_op());
            else if (pick == 8)
                send_beat(MODE_READ, 12'($urandom), 8'($urandom), 1'($urandom),
                          4'($urandom), 8'($urandom), 5'($urandom));
            else
                send_beat($urandom_range(0, 1) ? MODE_LOAD : MODE_NONE, 12'($urandom),
                          8'($urandom), 1'($urandom), 4'($urandom), 8'($urandom),
                          5'($urandom));
        end
        idle_pct = 0;
    endtask

    // only one error can be seen per run, the machine stays halted after it
    task automatic test_error_halt();
        if ($urandom_range(0, 1)) begin
            while (sp > 0) run_op({OP_SYS, 4'h0, NN_RET}, 0, 0, 0);
            run_op({OP_SYS, 4'h0, NN_RET}, 0, 0, 0);
        end else begin
            run_op({OP_ALU, 4'h1, 4'h2, 4'h8}, 0, 0, 0);
        end
        run_rand_keys(rand_op());
        send_beat(MODE_RUN, '0, '0, 1'b1, 4'h0, 8'h00, '0);
        send_beat(MODE_READ, '0, '0, 1'b0, '0, '0, 5'($urandom));
    endtask

    initial begin
        machine_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_start_addr(12'h000);
        test_directed();
        write_start_addr(12'hFFF);
        test_random(0, 400);
        test_random(47, 400);
        write_start_addr(12'($urandom));
        test_random(30, 400);
        test_stack_full();
        test_error_halt();
        wait_idle();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
